// ===== sv/tmfl_pkg.sv =====
// ----------------------------------------------------------------------------
// tmfl_pkg
// Types, codes and byte-class helpers shared by the lexer modules.
// ----------------------------------------------------------------------------
package tmfl_pkg;

	// result queue depth, must be at least 2
	localparam int RES_DEPTH = 4;

	typedef enum logic [3:0] {
		M_IDLE         = 4'd0,
		M_IDENT        = 4'd1,
		M_NUMBER       = 4'd2,
		M_QUOTE        = 4'd3,
		M_UUID         = 4'd4,
		M_SLASH        = 4'd5,
		M_COMMENT      = 4'd6,
		M_SKIP_SLASH   = 4'd7,
		M_SKIP_COMMENT = 4'd8
	} mode_t;

	localparam logic [3:0] K_UNREC   = 4'd0;
	localparam logic [3:0] K_IDENT   = 4'd1;
	localparam logic [3:0] K_INT     = 4'd2;
	localparam logic [3:0] K_FLOAT   = 4'd3;
	localparam logic [3:0] K_STRING  = 4'd4;
	localparam logic [3:0] K_COMMENT = 4'd5;
	localparam logic [3:0] K_LBRACE  = 4'd6;
	localparam logic [3:0] K_RBRACE  = 4'd7;
	localparam logic [3:0] K_LBRACK  = 4'd8;
	localparam logic [3:0] K_RBRACK  = 4'd9;
	localparam logic [3:0] K_COMMA   = 4'd10;
	localparam logic [3:0] K_SEMI    = 4'd11;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_SLASH   = 2'd1;
	localparam logic [1:0] ERR_UNTERM  = 2'd2;

	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] ch;
		logic       char_valid;
		logic       done;
		logic       stream_end;
		logic [1:0] err;
	} result_t;

	typedef struct packed {
		logic    emits;
		result_t res;
		mode_t   mode;
		logic [3:0] kind;
	} start_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {CH_SPACE, [8'h09:8'h0D]};
	endfunction

	function automatic logic is_identch(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
	endfunction

	function automatic result_t res_char(input logic [3:0] kind, input logic [7:0] c);
		result_t r;
		r = '0;
		r.kind = kind;
		r.ch = c;
		r.char_valid = 1'b1;
		return r;
	endfunction

	function automatic result_t res_close(input logic [3:0] kind);
		result_t r;
		r = '0;
		r.kind = kind;
		r.done = 1'b1;
		return r;
	endfunction

	function automatic result_t res_err(input logic [1:0] code);
		result_t r;
		r = '0;
		r.err = code;
		return r;
	endfunction

	function automatic result_t res_end();
		result_t r;
		r = '0;
		r.stream_end = 1'b1;
		return r;
	endfunction

	// first byte of a token: new mode and kind, and an optional result
	function automatic start_t start_token(input logic [7:0] c, input logic skip);
		start_t s;
		s = '0;
		s.mode = M_IDLE;
		s.kind = K_UNREC;
		if (is_space(c)) begin
			s.emits = 1'b0;
		end else if (is_alpha(c) || c == CH_UNDER) begin
			s.emits = 1'b1;
			s.mode = M_IDENT;
			s.kind = K_IDENT;
			s.res = res_char(K_IDENT, c);
		end else if (is_digit(c) || c == CH_MINUS || c == CH_PLUS) begin
			s.emits = 1'b1;
			s.mode = M_NUMBER;
			s.kind = K_INT;
			s.res = res_char(K_INT, c);
		end else if (c == CH_LT || c == CH_QUOTE) begin
			s.mode = (c == CH_LT) ? M_UUID : M_QUOTE;
			s.kind = K_STRING;
		end else if (c == CH_SLASH || c == CH_HASH) begin
			s.kind = K_COMMENT;
			if (skip) begin
				s.mode = (c == CH_SLASH) ? M_SKIP_SLASH : M_SKIP_COMMENT;
			end else begin
				s.mode = (c == CH_SLASH) ? M_SLASH : M_COMMENT;
			end
		end else begin
			s.emits = 1'b1;
			case (c)
				CH_LBRACE: s.res = res_close(K_LBRACE);
				CH_RBRACE: s.res = res_close(K_RBRACE);
				CH_LBRACK: s.res = res_close(K_LBRACK);
				CH_RBRACK: s.res = res_close(K_RBRACK);
				CH_COMMA:  s.res = res_close(K_COMMA);
				CH_SEMI:   s.res = res_close(K_SEMI);
				default:   s.res = res_close(K_UNREC);
			endcase
		end
		return s;
	endfunction

endpackage

// ===== sv/tmfl_core.sv =====
// ----------------------------------------------------------------------------
// tmfl_core
// Lexer state and the per-byte transition logic; yields up to two results.
// ----------------------------------------------------------------------------
module tmfl_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [7:0]        c,
	input  logic              eoi,
	input  logic              skip,
	output logic [1:0]        n,
	output tmfl_pkg::result_t r0,
	output tmfl_pkg::result_t r1
);
	import tmfl_pkg::*;

	mode_t      mode_q, mode_d;
	logic [3:0] kind_q, kind_d;
	logic       halted_q, halted_d;
	start_t     st;

	always_comb begin
		n = 2'd0;
		r0 = '0;
		r1 = '0;
		mode_d = mode_q;
		kind_d = kind_q;
		halted_d = halted_q;
		st = start_token(c, skip);
		if (halted_q) begin
			n = 2'd0;
		end else if (eoi) begin
			mode_d = M_IDLE;
			kind_d = K_UNREC;
			case (mode_q)
				M_IDENT, M_NUMBER, M_COMMENT: begin
					r0 = res_close(kind_q);
					r1 = res_end();
					n = 2'd2;
				end
				M_QUOTE, M_UUID: begin
					r0 = res_err(ERR_UNTERM);
					halted_d = 1'b1;
					n = 2'd1;
				end
				M_SLASH, M_SKIP_SLASH: begin
					r0 = res_err(ERR_SLASH);
					halted_d = 1'b1;
					n = 2'd1;
				end
				default: begin
					r0 = res_end();
					n = 2'd1;
				end
			endcase
		end else begin
			case (mode_q)
				M_IDENT, M_NUMBER: begin
					if (mode_q == M_IDENT && is_identch(c)) begin
						r0 = res_char(K_IDENT, c);
						n = 2'd1;
					end else if (mode_q == M_NUMBER && c == CH_DOT && kind_q == K_INT) begin
						kind_d = K_FLOAT;
						r0 = res_char(K_FLOAT, c);
						n = 2'd1;
					end else if (mode_q == M_NUMBER && is_digit(c)) begin
						r0 = res_char(kind_q, c);
						n = 2'd1;
					end else begin
						// the ending byte also opens the next token
						r0 = res_close(kind_q);
						r1 = st.res;
						n = st.emits ? 2'd2 : 2'd1;
						mode_d = st.mode;
						kind_d = st.kind;
					end
				end
				M_QUOTE, M_UUID: begin
					n = 2'd1;
					if (c == ((mode_q == M_QUOTE) ? CH_QUOTE : CH_GT)) begin
						r0 = res_close(kind_q);
						mode_d = M_IDLE;
						kind_d = K_UNREC;
					end else begin
						r0 = res_char(K_STRING, c);
					end
				end
				M_SLASH, M_SKIP_SLASH: begin
					if (c != CH_SLASH) begin
						r0 = res_err(ERR_SLASH);
						n = 2'd1;
						halted_d = 1'b1;
						mode_d = M_IDLE;
						kind_d = K_UNREC;
					end else begin
						mode_d = (mode_q == M_SLASH) ? M_COMMENT : M_SKIP_COMMENT;
					end
				end
				M_COMMENT: begin
					n = 2'd1;
					if (c == CH_NL) begin
						r0 = res_close(kind_q);
						mode_d = M_IDLE;
						kind_d = K_UNREC;
					end else begin
						r0 = res_char(K_COMMENT, c);
					end
				end
				M_SKIP_COMMENT: begin
					if (c == CH_NL) begin
						mode_d = M_IDLE;
						kind_d = K_UNREC;
					end
				end
				default: begin
					r0 = st.res;
					n = st.emits ? 2'd1 : 2'd0;
					mode_d = st.mode;
					kind_d = st.kind;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			kind_q <= K_UNREC;
			halted_q <= 1'b0;
		end else if (go) begin
			mode_q <= mode_d;
			kind_q <= kind_d;
			halted_q <= halted_d;
		end
	end

`ifndef SYNTHESIS
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag cleared without reset");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> n == 2'd0)
		else $error("results produced while halted");

	a_pair_closes: assert property (@(posedge clk) disable iff (!arst_n)
		n == 2'd2 |-> r0.done && r1.err == ERR_NONE)
		else $error("two results without a token close first");

	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		go && n != 2'd0 && r0.err != ERR_NONE |=> halted_q)
		else $error("error result did not halt the lexer");
`endif

endmodule

// ===== sv/tmfl_res_fifo.sv =====
// ----------------------------------------------------------------------------
// tmfl_res_fifo
// Small result queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
module tmfl_res_fifo #(
	parameter int DEPTH = tmfl_pkg::RES_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  tmfl_pkg::result_t w0,
	input  tmfl_pkg::result_t w1,
	output logic              room,
	output logic              rd_valid,
	input  logic              pop,
	output tmfl_pkg::result_t rd
);
	import tmfl_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t        mem_q [DEPTH];
	logic [PW-1:0]  wp_q, rp_q, wp1;
	logic [CW-1:0]  count_q;
	logic           do_pop;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wp1 = inc(wp_q);
	assign room = count_q <= CW'(DEPTH - 2);
	assign rd_valid = count_q != '0;
	assign rd = mem_q[rp_q];
	assign do_pop = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wp_q] <= w0;
		end
		if (push_n == 2'd2) begin
			mem_q[wp1] <= w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			case (push_n)
				2'd1:    wp_q <= wp1;
				2'd2:    wp_q <= inc(wp1);
				default: wp_q <= wp_q;
			endcase
			if (do_pop) begin
				rp_q <= inc(rp_q);
			end
			count_q <= count_q + CW'(push_n) - CW'(do_pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> count_q <= CW'(DEPTH - 2))
		else $error("result queue written without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue count out of range");

	a_head_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid && !pop |=> rd_valid && $stable(rd))
		else $error("stalled result changed");
`endif

endmodule

// ===== sv/text_mesh_format_lexer.sv =====
// ----------------------------------------------------------------------------
// text_mesh_format_lexer
// Streaming tokenizer for a text 3D model format, one byte per request.
// ----------------------------------------------------------------------------
// One input request (a byte or an end-of-input mark) is taken per cycle; it
// is registered, classified against the lexer state in a single pass, and
// its zero, one or two results go into a four-entry result queue that drains
// one result per cycle while out_stall is low. The input side stalls only
// while its register holds a byte and the queue has fewer than two free
// entries, so bytes that give one result each stream at one per cycle
// while out_stall is low. skip_comments (reset 1) must be written through
// the cfg port only while the lexer is idle; the block does not enforce it.
module text_mesh_format_lexer #(
	parameter int RES_DEPTH = tmfl_pkg::RES_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] token_kind,
	output logic [7:0] content_char,
	output logic       char_valid,
	output logic       token_done,
	output logic       stream_end,
	output logic [1:0] error_code,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);
	import tmfl_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;
	logic       skip_q;
	logic       room;
	logic       go;
	logic       take;
	logic [1:0] n;
	result_t    r0, r1, rd;

	assign cfg_ready = 1'b1;
	assign go = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				skip_q <= cfg_data;
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= char_in;
			eoi_s1 <= end_of_input;
		end
	end

	tmfl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.c      (char_s1),
		.eoi    (eoi_s1),
		.skip   (skip_q),
		.n      (n),
		.r0     (r0),
		.r1     (r1)
	);

	tmfl_res_fifo #(
		.DEPTH (RES_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (go ? n : 2'd0),
		.w0       (r0),
		.w1       (r1),
		.room     (room),
		.rd_valid (out_valid),
		.pop      (!out_stall),
		.rd       (rd)
	);

	assign token_kind = rd.kind;
	assign content_char = rd.ch;
	assign char_valid = rd.char_valid;
	assign token_done = rd.done;
	assign stream_end = rd.stream_end;
	assign error_code = rd.err;

`ifndef SYNTHESIS
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with an empty input register");

	a_go_consumes: assert property (@(posedge clk) disable iff (!arst_n)
		go && !take |=> !valid_s1)
		else $error("input register not freed after processing");

	a_take_holds: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted request lost");
`endif

endmodule
